>>> hw/rtl/rc_oscillator_trim_search_defines.svh
// ----------------------------------------------------------------------------
// RC oscillator trim search assertion macros
// Shared assertion forms for the checker of the trim search block.
// ----------------------------------------------------------------------------
`ifndef RC_OSCILLATOR_TRIM_SEARCH_DEFINES_SVH
`define RC_OSCILLATOR_TRIM_SEARCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCOTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcots: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RCOTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rcots: assertion failed");

`endif

>>> hw/rtl/rcots_pkg.sv
// ----------------------------------------------------------------------------
// RC oscillator trim search package
// Types and constants shared by the trim search modules.
// ----------------------------------------------------------------------------
package rcots_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned TrimW  = 8;
  localparam int unsigned ErrW   = 8;
  localparam int unsigned TallyW = 3;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned IdxW   = 2;

  localparam logic [IdxW-1:0] REG_TARGET_COUNT = 2'd0;
  localparam logic [IdxW-1:0] REG_INITIAL_STEP = 2'd1;
  localparam logic [IdxW-1:0] REG_INITIAL_TRIM = 2'd2;
  localparam logic [IdxW-1:0] REG_SEARCH_MODE  = 2'd3;

  localparam logic [ModeW-1:0] MODE_SIMPLE = 2'd0;
  localparam logic [ModeW-1:0] MODE_BINARY = 2'd1;

  localparam logic [CountW-1:0] TARGET_RESET = 16'd1000;
  localparam logic [TrimW-1:0]  STEP_RESET   = 8'd32;
  localparam logic [TrimW-1:0]  TRIM_RESET   = 8'h5E;
  localparam logic [ModeW-1:0]  MODE_RESET   = 2'd2;

  localparam logic [ErrW-1:0]   ERR_MAX       = 8'hFF;
  localparam logic [TallyW-1:0] NEIGHBOR_LAST = 3'd4;

  typedef enum logic [2:0] {
    PH_BINARY   = 3'b001,
    PH_NEIGHBOR = 3'b010,
    PH_DONE     = 3'b100
  } phase_t;

  typedef struct packed {
    logic [CountW-1:0] target_count;
    logic [TrimW-1:0]  initial_step;
    logic [TrimW-1:0]  initial_trim;
    logic [ModeW-1:0]  search_mode;
  } cfg_t;

  typedef struct packed {
    logic [TrimW-1:0]  trim;
    logic [TrimW-1:0]  step_size;
    phase_t            phase;
    logic [TallyW-1:0] neighbor_tally;
    logic              last_direction;
    logic [TrimW-1:0]  best_trim;
    logic [ErrW-1:0]   smallest_error;
  } search_state_t;

endpackage

>>> hw/rtl/rcots_step.sv
// ----------------------------------------------------------------------------
// RC oscillator trim search step
// Next search state from the current state, one item and the registers.
// ----------------------------------------------------------------------------
module rcots_step import rcots_pkg::*; (
  input  logic                func,
  input  logic [CountW-1:0]   measured_count,
  input  cfg_t                cfg,
  input  search_state_t       cur,
  output search_state_t       nxt
);

  logic              gt;
  logic              lt;
  logic [CountW-1:0] diff;
  logic [ErrW-1:0]   err;
  logic              better;
  logic [TrimW-1:0]  nb_best;
  logic [TallyW-1:0] tally_inc;

  always_comb begin
    gt        = measured_count > cfg.target_count;
    lt        = measured_count < cfg.target_count;
    diff      = gt ? (measured_count - cfg.target_count)
                   : (cfg.target_count - measured_count);
    err       = (diff > CountW'(ERR_MAX)) ? ERR_MAX : diff[ErrW-1:0];
    better    = err < cur.smallest_error;
    nb_best   = better ? cur.trim : cur.best_trim;
    tally_inc = cur.neighbor_tally + TallyW'(1);
  end

  always_comb begin
    nxt = cur;
    if (func) begin
      nxt.trim           = cfg.initial_trim;
      nxt.step_size      = cfg.initial_step;
      nxt.phase          = PH_BINARY;
      nxt.neighbor_tally = '0;
      nxt.last_direction = 1'b0;
      nxt.best_trim      = '0;
      nxt.smallest_error = ERR_MAX;
    end else if (cur.phase != PH_DONE) begin
      if (cfg.search_mode == MODE_SIMPLE) begin
        if (better) begin
          nxt.smallest_error = err;
          nxt.best_trim      = cur.trim;
        end
        if (gt) begin
          nxt.trim = cur.trim - TrimW'(1);
        end else if (lt) begin
          nxt.trim = cur.trim + TrimW'(1);
        end else begin
          nxt.phase = PH_DONE;
        end
      end else if (cur.phase == PH_BINARY) begin
        if (cur.step_size != '0) begin
          if (gt) begin
            nxt.last_direction = 1'b1;
            nxt.trim           = cur.trim - cur.step_size;
          end else if (lt) begin
            nxt.last_direction = 1'b0;
            nxt.trim           = cur.trim + cur.step_size;
          end else begin
            nxt.phase          = PH_DONE;
            nxt.best_trim      = cur.trim;
            nxt.smallest_error = '0;
          end
          nxt.step_size = cur.step_size >> 1;
        end else begin
          nxt.smallest_error = err;
          nxt.best_trim      = cur.trim;
          if (cfg.search_mode == MODE_BINARY) begin
            nxt.phase = PH_DONE;
          end else begin
            nxt.phase          = PH_NEIGHBOR;
            nxt.neighbor_tally = '0;
          end
        end
      end else begin
        nxt.smallest_error = better ? err : cur.smallest_error;
        nxt.best_trim      = nb_best;
        nxt.neighbor_tally = tally_inc;
        if (tally_inc >= NEIGHBOR_LAST) begin
          nxt.trim  = nb_best;
          nxt.phase = PH_DONE;
        end else if (cur.last_direction) begin
          nxt.trim = cur.trim - TrimW'(1);
        end else begin
          nxt.trim = cur.trim + TrimW'(1);
        end
      end
    end
  end

endmodule

>>> hw/rtl/rc_oscillator_trim_search.sv
// ----------------------------------------------------------------------------
// RC oscillator trim search
// Binary, linear or binary-plus-neighbor search calibration of an oscillator trim from measured counts.
// ----------------------------------------------------------------------------
// Path: each accepted item passes the input register and then the result register; a stalled output holds it.
// Throughput: one item per cycle while the output is not stalled; the search state updates in one pass
// between the input register and the result register.
// Reset: synchronous, active high; registers return to their reset values
// and the search state matches a restart with those values.
module rc_oscillator_trim_search import rcots_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                func,
  input  logic [CountW-1:0]   measured_count,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [TrimW-1:0]    trim_out,
  output logic                search_done,
  output logic [ErrW-1:0]     best_error,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IdxW-1:0]     cfg_index,
  input  logic [CountW-1:0]   cfg_data
);

  cfg_t              cfg;
  search_state_t     state;
  search_state_t     state_next;
  logic              in_full;
  logic              func_q;
  logic [CountW-1:0] count_q;
  logic              advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_count <= TARGET_RESET;
      cfg.initial_step <= STEP_RESET;
      cfg.initial_trim <= TRIM_RESET;
      cfg.search_mode  <= MODE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TARGET_COUNT: cfg.target_count <= cfg_data;
        REG_INITIAL_STEP: cfg.initial_step <= cfg_data[TrimW-1:0];
        REG_INITIAL_TRIM: cfg.initial_trim <= cfg_data[TrimW-1:0];
        REG_SEARCH_MODE:  cfg.search_mode  <= cfg_data[ModeW-1:0];
        default:          cfg.search_mode  <= cfg.search_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      func_q  <= func;
      count_q <= measured_count;
    end
  end

  rcots_step u_step (
    .func           (func_q),
    .measured_count (count_q),
    .cfg            (cfg),
    .cur            (state),
    .nxt            (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.trim           <= TRIM_RESET;
      state.step_size      <= STEP_RESET;
      state.phase          <= PH_BINARY;
      state.neighbor_tally <= '0;
      state.last_direction <= 1'b0;
      state.best_trim      <= '0;
      state.smallest_error <= ERR_MAX;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      trim_out    <= state_next.trim;
      search_done <= (state_next.phase == PH_DONE);
      best_error  <= state_next.smallest_error;
    end
  end

endmodule

>>> hw/rtl/rcots_checker.sv
// ----------------------------------------------------------------------------
// RC oscillator trim search checker
// Port level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "rc_oscillator_trim_search_defines.svh"

module rcots_checker import rcots_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [TrimW-1:0]  trim_out,
  input logic              search_done,
  input logic [ErrW-1:0]   best_error
);

  `RCOTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(trim_out) && $stable(search_done) && $stable(best_error))
  `RCOTS_ASSERT_NOW(a_no_stall_when_empty, !out_valid, !in_stall)
  `RCOTS_ASSERT_NOW(a_result_follows, in_valid && !in_stall, ##2 out_valid)

endmodule

bind rc_oscillator_trim_search rcots_checker u_rcots_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .trim_out    (trim_out),
  .search_done (search_done),
  .best_error  (best_error)
);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Trim search testbench
// Feeds measurement and restart items to the trim search block. The sender
// idles in bursts and the receiver stalls, and each result is compared with
// given values or with a predictor that holds its own copy of the search state and registers.
// ----------------------------------------------------------------------------
module testbench import rcots_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FUNC_MEASURE = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;
  localparam logic [ModeW-1:0] MODE_NEIGHBOR     = 2'd2;
  localparam logic [ModeW-1:0] MODE_NEIGHBOR_ALT = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 1130;

  typedef struct packed {
    logic [TrimW-1:0] trim;
    logic             done;
    logic [ErrW-1:0]  err;
  } trim_result_t;

  typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic              fn;
    logic [CountW-1:0] count;
    logic [IdxW-1:0]   idx;
    logic [CountW-1:0] data;
    logic              typed;
    trim_result_t      exp;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              func = 1'b0;
  logic [CountW-1:0] measured_count = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [TrimW-1:0]  trim_out;
  logic              search_done;
  logic [ErrW-1:0]   best_error;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IdxW-1:0]   cfg_index = '0;
  logic [CountW-1:0] cfg_data = '0;

  cfg_t          reg_shadow;
  search_state_t cal_state;
  trim_result_t  pending_results[$];
  int            mismatches = 0;
  logic [8:0]    stall_cycle = '0;

  rc_oscillator_trim_search u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void restart_search();
    cal_state.trim           = reg_shadow.initial_trim;
    cal_state.step_size      = reg_shadow.initial_step;
    cal_state.phase          = PH_BINARY;
    cal_state.neighbor_tally = '0;
    cal_state.last_direction = 1'b0;
    cal_state.best_trim      = '0;
    cal_state.smallest_error = ERR_MAX;
  endfunction

  function automatic trim_result_t advance_search(input logic fn,
                                                  input logic [CountW-1:0] count);
    logic              above;
    logic              below;
    logic [CountW-1:0] gap;
    logic [ErrW-1:0]   err;
    trim_result_t      res;
    above = count > reg_shadow.target_count;
    below = count < reg_shadow.target_count;
    gap   = above ? count - reg_shadow.target_count : reg_shadow.target_count - count;
    err   = (gap > CountW'(ERR_MAX)) ? ERR_MAX : gap[ErrW-1:0];
    if (fn == FUNC_RESTART) begin
      restart_search();
    end else if (cal_state.phase != PH_DONE) begin
      if (reg_shadow.search_mode == MODE_SIMPLE) begin
        if (err < cal_state.smallest_error) begin
          cal_state.smallest_error = err;
          cal_state.best_trim      = cal_state.trim;
        end
        if (above) begin
          cal_state.trim = cal_state.trim - 8'd1;
        end else if (below) begin
          cal_state.trim = cal_state.trim + 8'd1;
        end else begin
          cal_state.phase = PH_DONE;
        end
      end else if (cal_state.phase == PH_BINARY) begin
        if (cal_state.step_size != '0) begin
          if (above) begin
            cal_state.last_direction = 1'b1;
            cal_state.trim           = cal_state.trim - cal_state.step_size;
          end else if (below) begin
            cal_state.last_direction = 1'b0;
            cal_state.trim           = cal_state.trim + cal_state.step_size;
          end else begin
            cal_state.phase          = PH_DONE;
            cal_state.best_trim      = cal_state.trim;
            cal_state.smallest_error = '0;
          end
          cal_state.step_size = cal_state.step_size >> 1;
        end else begin
          cal_state.smallest_error = err;
          cal_state.best_trim      = cal_state.trim;
          if (reg_shadow.search_mode == MODE_BINARY) begin
            cal_state.phase = PH_DONE;
          end else begin
            cal_state.phase          = PH_NEIGHBOR;
            cal_state.neighbor_tally = '0;
          end
        end
      end else begin
        if (err < cal_state.smallest_error) begin
          cal_state.smallest_error = err;
          cal_state.best_trim      = cal_state.trim;
        end
        cal_state.neighbor_tally = cal_state.neighbor_tally + 3'd1;
        if (cal_state.neighbor_tally >= NEIGHBOR_LAST) begin
          cal_state.trim  = cal_state.best_trim;
          cal_state.phase = PH_DONE;
        end else if (cal_state.last_direction) begin
          cal_state.trim = cal_state.trim - 8'd1;
        end else begin
          cal_state.trim = cal_state.trim + 8'd1;
        end
      end
    end
    res.trim = cal_state.trim;
    res.done = (cal_state.phase == PH_DONE);
    res.err  = cal_state.smallest_error;
    return res;
  endfunction

  function automatic stim_row_t item_row(input logic fn, input logic [CountW-1:0] count);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_ITEM;
    row.fn    = fn;
    row.count = count;
    return row;
  endfunction

  function automatic stim_row_t typed_row(input logic fn, input logic [CountW-1:0] count,
                                          input logic [TrimW-1:0] trim, input logic done,
                                          input logic [ErrW-1:0] err);
    stim_row_t row;
    row          = item_row(fn, count);
    row.typed    = 1'b1;
    row.exp.trim = trim;
    row.exp.done = done;
    row.exp.err  = err;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [IdxW-1:0] idx,
                                        input logic [CountW-1:0] data);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_REG;
    row.idx  = idx;
    row.data = data;
    return row;
  endfunction

  function automatic logic [CountW-1:0] pick_count();
    int value;
    int spread;
    case ($urandom_range(0, 9))
      0: value = int'(reg_shadow.target_count);
      1, 2, 3, 4, 5: begin
        case ($urandom_range(0, 2))
          0: spread = 4;
          1: spread = 40;
          default: spread = 400;
        endcase
        value = int'(reg_shadow.target_count) + int'($urandom_range(0, 2 * spread)) - spread;
      end
      6: value = int'(reg_shadow.target_count) + ($urandom_range(0, 1) ? 255 : -255)
                 + int'($urandom_range(0, 2)) - 1;
      7: value = $urandom_range(0, 1) ? 0 : 65535;
      default: value = int'($urandom_range(0, 65535));
    endcase
    if (value < 0) begin
      value = 0;
    end else if (value > 65535) begin
      value = 65535;
    end
    return value[CountW-1:0];
  endfunction

  function automatic logic [CountW-1:0] pick_reg_value(input logic [IdxW-1:0] idx);
    logic [CountW-1:0] value;
    case (idx)
      REG_TARGET_COUNT: begin
        case ($urandom_range(0, 5))
          0: value = '0;
          1: value = '1;
          default: value = CountW'($urandom_range(0, 65535));
        endcase
      end
      REG_INITIAL_STEP: begin
        case ($urandom_range(0, 7))
          0: value = 16'd0;
          1: value = 16'd128;
          2: value = 16'd32;
          default: value = CountW'($urandom_range(1, 8));
        endcase
      end
      REG_INITIAL_TRIM: begin
        case ($urandom_range(0, 5))
          0: value = 16'd0;
          1: value = 16'd255;
          default: value = CountW'($urandom_range(0, 255));
        endcase
      end
      default: value = CountW'($urandom_range(0, 3));
    endcase
    return value;
  endfunction

  task automatic send_item(input logic fn, input logic [CountW-1:0] count,
                           input logic typed, input trim_result_t given);
    trim_result_t predicted;
    in_valid       <= 1'b1;
    func           <= fn;
    measured_count <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = advance_search(fn, count);
    pending_results.push_back(typed ? given : predicted);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CountW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TARGET_COUNT: reg_shadow.target_count = data;
      REG_INITIAL_STEP: reg_shadow.initial_step = data[TrimW-1:0];
      REG_INITIAL_TRIM: reg_shadow.initial_trim = data[TrimW-1:0];
      default:          reg_shadow.search_mode  = data[ModeW-1:0];
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 9'd1;
    case (stall_cycle[8:7])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_cycle[1];
    endcase
  end

  always @(posedge clk) begin : check_results
    trim_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: trim_out %0d, search_done %0d, best_error %0d",
               trim_out, search_done, best_error);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (trim_out !== want.trim) begin
          $error("trim_out: expected %0d, actual %0d", want.trim, trim_out);
          mismatches++;
        end
        if (search_done !== want.done) begin
          $error("search_done: expected %0d, actual %0d", want.done, search_done);
          mismatches++;
        end
        if (best_error !== want.err) begin
          $error("best_error: expected %0d, actual %0d", want.err, best_error);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t dir_rows[$];
    int        sent;
    int        burst_left;
    int        phase_len;
    logic      fn;
    reg_shadow = '{TARGET_RESET, STEP_RESET, TRIM_RESET, MODE_RESET};
    restart_search();

    dir_rows.push_back(typed_row(FUNC_RESTART, 16'd0, 8'd94, 1'b0, 8'd255));
    dir_rows.push_back(typed_row(FUNC_MEASURE, 16'd1000, 8'd94, 1'b1, 8'd0));
    dir_rows.push_back(typed_row(FUNC_MEASURE, 16'd0, 8'd94, 1'b1, 8'd0));
    dir_rows.push_back(typed_row(FUNC_RESTART, 16'hFFFF, 8'd94, 1'b0, 8'd255));
    dir_rows.push_back(typed_row(FUNC_MEASURE, 16'hFFFF, 8'd62, 1'b0, 8'd255));
    dir_rows.push_back(reg_row(REG_SEARCH_MODE, CountW'(MODE_BINARY)));
    dir_rows.push_back(reg_row(REG_INITIAL_STEP, 16'd1));
    dir_rows.push_back(typed_row(FUNC_RESTART, 16'd0, 8'd94, 1'b0, 8'd255));
    dir_rows.push_back(typed_row(FUNC_MEASURE, 16'd0, 8'd95, 1'b0, 8'd255));
    dir_rows.push_back(typed_row(FUNC_MEASURE, 16'hFFFF, 8'd95, 1'b1, 8'd255));
    dir_rows.push_back(reg_row(REG_SEARCH_MODE, CountW'(MODE_SIMPLE)));
    dir_rows.push_back(reg_row(REG_TARGET_COUNT, 16'd0));
    dir_rows.push_back(reg_row(REG_INITIAL_TRIM, 16'd255));
    dir_rows.push_back(typed_row(FUNC_RESTART, 16'd0, 8'd255, 1'b0, 8'd255));
    dir_rows.push_back(typed_row(FUNC_MEASURE, 16'd5, 8'd254, 1'b0, 8'd5));
    dir_rows.push_back(typed_row(FUNC_MEASURE, 16'd0, 8'd254, 1'b1, 8'd0));
    dir_rows.push_back(reg_row(REG_TARGET_COUNT, 16'hFFFF));
    dir_rows.push_back(reg_row(REG_INITIAL_TRIM, 16'd0));
    dir_rows.push_back(reg_row(REG_INITIAL_STEP, 16'd128));
    dir_rows.push_back(reg_row(REG_SEARCH_MODE, CountW'(MODE_NEIGHBOR_ALT)));
    dir_rows.push_back(typed_row(FUNC_RESTART, 16'd0, 8'd0, 1'b0, 8'd255));
    dir_rows.push_back(typed_row(FUNC_MEASURE, 16'd0, 8'd128, 1'b0, 8'd255));
    dir_rows.push_back(typed_row(FUNC_MEASURE, 16'hFFFF, 8'd128, 1'b1, 8'd0));
    dir_rows.push_back(reg_row(REG_INITIAL_STEP, 16'd0));
    dir_rows.push_back(reg_row(REG_INITIAL_TRIM, 16'd255));
    dir_rows.push_back(reg_row(REG_SEARCH_MODE, CountW'(MODE_NEIGHBOR)));
    dir_rows.push_back(typed_row(FUNC_RESTART, 16'h1234, 8'd255, 1'b0, 8'd255));
    dir_rows.push_back(typed_row(FUNC_MEASURE, 16'hFFFE, 8'd255, 1'b0, 8'd1));
    dir_rows.push_back(item_row(FUNC_MEASURE, 16'd0));
    dir_rows.push_back(item_row(FUNC_MEASURE, 16'd0));
    dir_rows.push_back(item_row(FUNC_MEASURE, 16'hFFFF));
    dir_rows.push_back(item_row(FUNC_MEASURE, 16'hFFFF));
    dir_rows.push_back(item_row(FUNC_MEASURE, 16'h8000));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        drain_results();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_item(dir_rows[i].fn, dir_rows[i].count, dir_rows[i].typed, dir_rows[i].exp);
      end
    end

    sent       = 0;
    burst_left = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      write_reg(REG_TARGET_COUNT, pick_reg_value(REG_TARGET_COUNT));
      write_reg(REG_INITIAL_STEP, pick_reg_value(REG_INITIAL_STEP));
      write_reg(REG_INITIAL_TRIM, pick_reg_value(REG_INITIAL_TRIM));
      write_reg(REG_SEARCH_MODE, pick_reg_value(REG_SEARCH_MODE));
      send_item(FUNC_RESTART, CountW'($urandom_range(0, 65535)), 1'b0, '0);
      sent++;
      phase_len = $urandom_range(30, 90);
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 3) != 0) begin
            pause_sender($urandom_range(1, 8));
          end
        end
        burst_left--;
        if ($urandom_range(0, 149) == 0) begin
          drain_results();
        end
        if (cal_state.phase == PH_DONE) begin
          fn = ($urandom_range(0, 9) < 6) ? FUNC_RESTART : FUNC_MEASURE;
        end else begin
          fn = ($urandom_range(0, 29) == 0) ? FUNC_RESTART : FUNC_MEASURE;
        end
        sent++;
        send_item(fn, (fn == FUNC_RESTART) ? CountW'($urandom_range(0, 65535)) : pick_count(),
                  1'b0, '0);
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
